### sv/rgb_color_temperature_assert.svh
// Assertion macros used by the top RTL file of the color temperature block.
`ifndef RGB_COLOR_TEMPERATURE_ASSERT_SVH
`define RGB_COLOR_TEMPERATURE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define RCT_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rgb_color_temperature: invariant violated");

// Condition that must hold in the same cycle as its trigger.
`define RCT_ASSERT_IMPLIES(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rgb_color_temperature: implication violated");

`endif

### sv/rct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rct_pkg;

	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int RATIO_FRAC_BITS_DEF = 24;

	localparam int QUOT_BITS = 31;
	localparam logic [31:0] RATIO_LIMIT = 32'h7FFF_FFFF;

	localparam longint MAT_E5 [0:8] = '{
		-14282, 154924, -95641,
		-32466, 157837, -73191,
		-68202,  77073,  56332
	};

	localparam int HORNER_STEPS = 3;
	localparam logic signed [31:0] HORNER_INIT = 32'sd44900;
	localparam logic signed [63:0] HORNER_ADD [0:2] = '{64'sd352500, 64'sd682330, 64'sd552033};

	localparam logic [31:0] DIV100_MUL = 32'd2748779070;
	localparam int DIV100_SHIFT = 38;
	localparam logic signed [31:0] CCT_NEG_MIN = -32'sd100;
	localparam logic signed [31:0] CCT_POS_MAX = 32'sd6553600;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_SAT = 2'd1;
	localparam logic [1:0] STAT_DEGEN = 2'd2;

	typedef struct packed {
		logic [15:0] red_count;
		logic [15:0] green_count;
		logic [15:0] blue_count;
	} rct_in_t;

	typedef struct packed {
		logic [15:0] color_temp_kelvin;
		logic [15:0] illuminance;
		logic [1:0]  temp_status;
		logic        lux_clamped;
	} rct_out_t;

	typedef struct packed {
		logic [15:0] lux;
		logic        lux_clamped;
		logic        degen;
		logic        sat;
	} rct_side_t;

	// Round k * 1e-5 to frac fraction bits, ties away from zero.
	function automatic longint round_e5(input longint k, input int frac);
		longint num;
		num = k * (longint'(1) <<< frac);
		if (num < 0) begin
			return (num - 50000) / 100000;
		end
		return (num + 50000) / 100000;
	endfunction

	// Round k * 1e-4 to frac fraction bits, ties away from zero.
	function automatic longint round_e4(input longint k, input int frac);
		longint num;
		num = k * (longint'(1) <<< frac);
		if (num < 0) begin
			return (num - 5000) / 10000;
		end
		return (num + 5000) / 10000;
	endfunction

endpackage
`default_nettype wire

### sv/rgb_color_temperature.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Valid       Ready       Payload
// input     rgb_valid   rgb_ready   rgb (red_count, green_count, blue_count)
// output    cct_valid   cct_ready   cct (color_temp_kelvin, illuminance, temp_status,
//                                        lux_clamped)
// One beat is accepted per cycle unless the pipeline holds; each passes from input to
// output through three matrix stages, two chained 33-stage restoring dividers with one
// stage between them, and eight Horner and scaling stages.
// Reset clears only the valid bits of the pipeline.
// While a result waits and cct_ready is low, the whole pipeline holds.
`include "rgb_color_temperature_assert.svh"
module rgb_color_temperature #(
	parameter int COEF_FRAC_BITS = rct_pkg::COEF_FRAC_BITS_DEF,
	parameter int RATIO_FRAC_BITS = rct_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rgb_valid,
	output logic              rgb_ready,
	input  rct_pkg::rct_in_t  rgb,
	output logic              cct_valid,
	input  logic              cct_ready,
	output rct_pkg::rct_out_t cct
);
	import rct_pkg::*;

	localparam int SW = COEF_FRAC_BITS + 23;
	localparam int NW = 33;
	localparam logic signed [NW-1:0] C332 = NW'(round_e4(3320, RATIO_FRAC_BITS));
	localparam logic signed [NW-1:0] C1858 = NW'(round_e4(1858, RATIO_FRAC_BITS));

	logic adv;
	logic m_vld;
	logic [SW-1:0] x_mag, y_mag, s_mag;
	logic x_neg, y_neg, lux_clamped, zero_sum;
	logic [15:0] lux;

	logic xvld, yvld, xsat, ysat, nvld, nsat;
	logic signed [31:0] xq, yq, nq;
	logic [16:0] xside;
	logic [0:0] yside;
	logic [$bits(rct_side_t)-1:0] nside;

	logic signed [NW-1:0] num_c, den_c;
	rct_side_t side_c;

	logic vld_s1, n_neg_s1;
	logic [NW-1:0] num_mag_s1, den_mag_s1;
	rct_side_t side_s1;

	assign adv = !cct_valid || cct_ready;
	assign rgb_ready = adv;

	rct_matrix #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_matrix (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_vld     (rgb_valid),
		.in_beat    (rgb),
		.out_vld    (m_vld),
		.x_mag      (x_mag),
		.y_mag      (y_mag),
		.s_mag      (s_mag),
		.x_neg      (x_neg),
		.y_neg      (y_neg),
		.lux        (lux),
		.lux_clamped(lux_clamped),
		.zero_sum   (zero_sum)
	);

	rct_div #(
		.W(SW),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS),
		.SIDE_W(17)
	) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (m_vld),
		.a_mag   (x_mag),
		.b_mag   (s_mag),
		.neg     (x_neg),
		.side_in ({lux, lux_clamped}),
		.out_vld (xvld),
		.q       (xq),
		.sat     (xsat),
		.side_out(xside)
	);

	rct_div #(
		.W(SW),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS),
		.SIDE_W(1)
	) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (m_vld),
		.a_mag   (y_mag),
		.b_mag   (s_mag),
		.neg     (y_neg),
		.side_in (zero_sum),
		.out_vld (yvld),
		.q       (yq),
		.sat     (ysat),
		.side_out(yside)
	);

	always_comb begin
		num_c = {xq[31], xq} - C332;
		den_c = C1858 - {yq[31], yq};
		side_c.lux = xside[16:1];
		side_c.lux_clamped = xside[0];
		side_c.degen = yside[0] || (den_c == '0);
		side_c.sat = xsat || ysat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= xvld && yvld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_mag_s1 <= num_c[NW-1] ? NW'(-num_c) : num_c;
			den_mag_s1 <= den_c[NW-1] ? NW'(-den_c) : den_c;
			n_neg_s1 <= num_c[NW-1] ^ den_c[NW-1];
			side_s1 <= side_c;
		end
	end

	rct_div #(
		.W(NW),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS),
		.SIDE_W($bits(rct_side_t))
	) u_div_n (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s1),
		.a_mag   (num_mag_s1),
		.b_mag   (den_mag_s1),
		.neg     (n_neg_s1),
		.side_in (side_s1),
		.out_vld (nvld),
		.q       (nq),
		.sat     (nsat),
		.side_out(nside)
	);

	rct_side_t h_side;
	always_comb begin
		h_side = rct_side_t'(nside);
		h_side.sat = h_side.sat || nsat;
	end

	rct_horner #(
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_horner (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (nvld),
		.n       (nq),
		.side    (h_side),
		.out_vld (cct_valid),
		.out_beat(cct)
	);

	`RCT_ASSERT_ALWAYS(a_div_lockstep, xvld == yvld)
	`RCT_ASSERT_IMPLIES(a_den_nonzero, vld_s1 && !side_s1.degen, den_mag_s1 != '0)
	`RCT_ASSERT_IMPLIES(a_degen_zero, cct_valid && cct.temp_status == STAT_DEGEN, cct.color_temp_kelvin == 16'd0)
endmodule
`default_nettype wire

### sv/rct_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
module rct_matrix #(
	parameter int COEF_FRAC_BITS = rct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_vld,
	input  rct_pkg::rct_in_t          in_beat,
	output logic                      out_vld,
	output logic [COEF_FRAC_BITS+22:0] x_mag,
	output logic [COEF_FRAC_BITS+22:0] y_mag,
	output logic [COEF_FRAC_BITS+22:0] s_mag,
	output logic                      x_neg,
	output logic                      y_neg,
	output logic [15:0]               lux,
	output logic                      lux_clamped,
	output logic                      zero_sum
);
	import rct_pkg::*;

	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int PW = CW + 17;
	localparam int TW = PW + 2;
	localparam int SW = TW + 2;
	localparam logic signed [TW-1:0] LUX_MIN = -(TW'(1) << COEF_FRAC_BITS);
	localparam logic signed [TW-1:0] LUX_MAX = TW'(65536) << COEF_FRAC_BITS;

	logic [15:0] ch [3];
	logic vld_s1, vld_s2, vld_s3;
	logic signed [PW-1:0] prod_s1 [9];
	logic signed [TW-1:0] trist_s2 [3];
	logic [SW-1:0] x_mag_s3, y_mag_s3, s_mag_s3;
	logic x_neg_s3, y_neg_s3, zero_s3, clamp_s3;
	logic [15:0] lux_s3;
	logic signed [SW-1:0] sum_c, x_c, y_c;
	logic signed [TW-1:0] t1;

	assign ch[0] = in_beat.red_count;
	assign ch[1] = in_beat.green_count;
	assign ch[2] = in_beat.blue_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_prod
		localparam logic signed [CW-1:0] COEF = CW'(round_e5(MAT_E5[k], COEF_FRAC_BITS));
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s1[k] <= COEF * $signed({1'b0, ch[k % 3]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				trist_s2[i] <= TW'(prod_s1[3*i]) + TW'(prod_s1[3*i+1]) + TW'(prod_s1[3*i+2]);
			end
		end
	end

	always_comb begin
		x_c = SW'(trist_s2[0]);
		y_c = SW'(trist_s2[1]);
		sum_c = x_c + y_c + SW'(trist_s2[2]);
		t1 = trist_s2[1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_mag_s3 <= x_c[SW-1] ? SW'(-x_c) : x_c;
			y_mag_s3 <= y_c[SW-1] ? SW'(-y_c) : y_c;
			s_mag_s3 <= sum_c[SW-1] ? SW'(-sum_c) : sum_c;
			x_neg_s3 <= x_c[SW-1] ^ sum_c[SW-1];
			y_neg_s3 <= y_c[SW-1] ^ sum_c[SW-1];
			zero_s3 <= (sum_c == '0);
			if (t1 <= LUX_MIN) begin
				lux_s3 <= 16'd0;
				clamp_s3 <= 1'b1;
			end else if (t1 < 0) begin
				lux_s3 <= 16'd0;
				clamp_s3 <= 1'b0;
			end else if (t1 >= LUX_MAX) begin
				lux_s3 <= 16'hFFFF;
				clamp_s3 <= 1'b1;
			end else begin
				lux_s3 <= t1[COEF_FRAC_BITS +: 16];
				clamp_s3 <= 1'b0;
			end
		end
	end

	assign out_vld = vld_s3;
	assign x_mag = x_mag_s3;
	assign y_mag = y_mag_s3;
	assign s_mag = s_mag_s3;
	assign x_neg = x_neg_s3;
	assign y_neg = y_neg_s3;
	assign lux = lux_s3;
	assign lux_clamped = clamp_s3;
	assign zero_sum = zero_s3;
endmodule
`default_nettype wire

### sv/rct_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rct_div #(
	parameter int W = 39,
	parameter int RATIO_FRAC_BITS = rct_pkg::RATIO_FRAC_BITS_DEF,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  logic [W-1:0]      a_mag,
	input  logic [W-1:0]      b_mag,
	input  logic              neg,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic signed [31:0] q,
	output logic              sat,
	output logic [SIDE_W-1:0] side_out
);
	import rct_pkg::*;

	localparam int SH = QUOT_BITS - RATIO_FRAC_BITS;

	logic              vld_s  [QUOT_BITS+1];
	logic [W-1:0]      rem_s  [QUOT_BITS+1];
	logic [QUOT_BITS-1:0] low_s [QUOT_BITS+1];
	logic [QUOT_BITS-1:0] quo_s [QUOT_BITS+1];
	logic [W-1:0]      b_s    [QUOT_BITS+1];
	logic              neg_s  [QUOT_BITS+1];
	logic              sat_s  [QUOT_BITS+1];
	logic [SIDE_W-1:0] side_s [QUOT_BITS+1];

	logic              vld_o;
	logic signed [31:0] q_o;
	logic              sat_o;
	logic [SIDE_W-1:0] side_o;

	logic [W+RATIO_FRAC_BITS-1:0] a_ext;
	logic [W+SH-1:0] b_sh;
	logic signed [31:0] qv;

	assign a_ext = {a_mag, {RATIO_FRAC_BITS{1'b0}}};
	assign b_sh = {b_mag, {SH{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= W'(a_mag >> SH);
			low_s[0] <= a_ext[QUOT_BITS-1:0];
			quo_s[0] <= '0;
			b_s[0] <= b_mag;
			neg_s[0] <= neg;
			sat_s[0] <= ({{SH{1'b0}}, a_mag} >= b_sh);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_step
		logic [W:0] trial, diff;
		logic ge;
		assign trial = {rem_s[k-1], low_s[k-1][QUOT_BITS-1]};
		assign diff = trial - {1'b0, b_s[k-1]};
		assign ge = (trial >= {1'b0, b_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? diff[W-1:0] : trial[W-1:0];
				low_s[k] <= {low_s[k-1][QUOT_BITS-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][QUOT_BITS-2:0], ge};
				b_s[k] <= b_s[k-1];
				neg_s[k] <= neg_s[k-1];
				sat_s[k] <= sat_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign qv = $signed({1'b0, quo_s[QUOT_BITS]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (adv) begin
			vld_o <= vld_s[QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sat_s[QUOT_BITS]) begin
				q_o <= neg_s[QUOT_BITS] ? -$signed(RATIO_LIMIT) : $signed(RATIO_LIMIT);
			end else begin
				q_o <= neg_s[QUOT_BITS] ? -qv : qv;
			end
			sat_o <= sat_s[QUOT_BITS];
			side_o <= side_s[QUOT_BITS];
		end
	end

	assign out_vld = vld_o;
	assign q = q_o;
	assign sat = sat_o;
	assign side_out = side_o;
endmodule
`default_nettype wire

### sv/rct_horner.sv
`timescale 1ns / 1ps
`default_nettype none
module rct_horner #(
	parameter int RATIO_FRAC_BITS = rct_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  logic signed [31:0] n,
	input  rct_pkg::rct_side_t side,
	output logic               out_vld,
	output rct_pkg::rct_out_t  out_beat
);
	import rct_pkg::*;

	localparam logic signed [63:0] LIM = 64'sh7FFF_FFFF;
	localparam logic signed [63:0] NLIM = -64'sh7FFF_FFFF;
	localparam logic signed [63:0] BIAS = (64'sd1 <<< RATIO_FRAC_BITS) - 64'sd1;

	logic signed [63:0] prod_s [HORNER_STEPS];
	logic signed [31:0] nm_s   [HORNER_STEPS];
	logic signed [31:0] na_s   [HORNER_STEPS];
	logic signed [31:0] acc_s  [HORNER_STEPS];
	rct_side_t          sm_s   [HORNER_STEPS];
	rct_side_t          sa_s   [HORNER_STEPS];
	logic               vm_s   [HORNER_STEPS];
	logic               va_s   [HORNER_STEPS];

	for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
		logic signed [31:0] acc_src, n_src;
		rct_side_t side_src, side_nxt;
		logic vld_src;
		logic signed [63:0] quo, val;
		logic over, under;

		if (g == 0) begin : g_first
			assign acc_src = HORNER_INIT;
			assign n_src = n;
			assign side_src = side;
			assign vld_src = in_vld;
		end else begin : g_next
			assign acc_src = acc_s[g-1];
			assign n_src = na_s[g-1];
			assign side_src = sa_s[g-1];
			assign vld_src = va_s[g-1];
		end

		always_comb begin
			quo = (prod_s[g] + (prod_s[g][63] ? BIAS : 64'sd0)) >>> RATIO_FRAC_BITS;
			val = quo + HORNER_ADD[g];
			over = (val > LIM);
			under = (val < NLIM);
			side_nxt = sm_s[g];
			side_nxt.sat = sm_s[g].sat | over | under;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vm_s[g] <= 1'b0;
				va_s[g] <= 1'b0;
			end else if (adv) begin
				vm_s[g] <= vld_src;
				va_s[g] <= vm_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s[g] <= acc_src * n_src;
				nm_s[g] <= n_src;
				sm_s[g] <= side_src;
				acc_s[g] <= over ? LIM[31:0] : (under ? NLIM[31:0] : val[31:0]);
				na_s[g] <= nm_s[g];
				sa_s[g] <= side_nxt;
			end
		end
	end

	logic signed [31:0] acc_f;
	logic neg_sat, pos_sat;
	logic [22:0] x_c;
	rct_side_t side_f;
	logic vld_s1, vld_s2;
	logic [54:0] prod_s1;
	logic pos_s1;
	rct_side_t side_s1;
	rct_out_t out_s2;

	always_comb begin
		acc_f = acc_s[HORNER_STEPS-1];
		neg_sat = (acc_f <= CCT_NEG_MIN);
		pos_sat = (acc_f >= CCT_POS_MAX);
		x_c = (!acc_f[31] && !pos_sat) ? acc_f[22:0] : 23'd0;
		side_f = sa_s[HORNER_STEPS-1];
		side_f.sat = sa_s[HORNER_STEPS-1].sat | neg_sat | pos_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= va_s[HORNER_STEPS-1];
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= x_c * DIV100_MUL;
			pos_s1 <= pos_sat;
			side_s1 <= side_f;
			out_s2.illuminance <= side_s1.lux;
			out_s2.lux_clamped <= side_s1.lux_clamped;
			if (side_s1.degen) begin
				out_s2.color_temp_kelvin <= 16'd0;
				out_s2.temp_status <= STAT_DEGEN;
			end else begin
				out_s2.color_temp_kelvin <= pos_s1 ? 16'hFFFF : prod_s1[DIV100_SHIFT +: 16];
				out_s2.temp_status <= side_s1.sat ? STAT_SAT : STAT_OK;
			end
		end
	end

	assign out_vld = vld_s2;
	assign out_beat = out_s2;
endmodule
`default_nettype wire
